[hw/rtl/atp_pkg.sv]
package atp_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int GAIN_BITS_DEF  = 16;
    localparam int GAIN_FRAC      = 8;
    localparam int INTEG_BITS     = 32;
    localparam int TORQUE_BITS    = 32;
    localparam int FF_BITS        = 16;
    localparam int GAINS_REG_BITS = 48;
    localparam int THRESH_BITS    = 15;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 15'd10;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROLL_GAINS  = 2'd0,
        CFG_PITCH_GAINS = 2'd1,
        CFG_YAW_GAINS   = 2'd2,
        CFG_YAW_THRESH  = 2'd3
    } t_cfg_idx;

    // stage load strobes, stage 4 is the output register
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_load;

    // yaw hold decisions for the item being accepted
    typedef struct packed {
        logic clr_integ;
        logic published;
        logic first;
    } t_hold;

endpackage

[hw/rtl/atp_hold.sv]
module atp_hold #(
    parameter int ANGLE_BITS = atp_pkg::ANGLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic signed [ANGLE_BITS-1:0]          i_yaw,
    input  logic signed [atp_pkg::FF_BITS-1:0]    i_cmd,
    input  logic        [atp_pkg::THRESH_BITS-1:0] i_thresh,
    output logic signed [ANGLE_BITS-1:0]          o_setpoint,
    output atp_pkg::t_hold                        o_hold
);

    logic signed [ANGLE_BITS-1:0] r_target;
    logic                         r_tvalid;
    logic                         r_rel_pend;
    logic                         r_first;

    logic signed [atp_pkg::FF_BITS:0] w_cmd_ext;
    logic        [atp_pkg::FF_BITS:0] w_mag;
    logic                             w_active;
    logic                             w_capture;

    assign w_cmd_ext = (atp_pkg::FF_BITS+1)'(i_cmd);
    assign w_mag     = $unsigned(w_cmd_ext[atp_pkg::FF_BITS] ? -w_cmd_ext : w_cmd_ext);
    assign w_active  = w_mag > (atp_pkg::FF_BITS+1)'(i_thresh);
    assign w_capture = !r_tvalid || w_active || r_rel_pend;

    assign o_setpoint       = w_capture ? i_yaw : r_target;
    assign o_hold.clr_integ = w_active || r_rel_pend;
    assign o_hold.published = !w_active && r_rel_pend;
    assign o_hold.first     = r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_tvalid   <= 1'b0;
            r_rel_pend <= 1'b0;
            r_first    <= 1'b1;
        end else if (i_accept) begin
            r_target   <= o_setpoint;
            r_tvalid   <= 1'b1;
            r_rel_pend <= w_active;
            r_first    <= 1'b0;
        end
    end

endmodule

[hw/rtl/atp_lane.sv]
module atp_lane #(
    parameter int ANGLE_BITS = atp_pkg::ANGLE_BITS_DEF,
    parameter int GAIN_BITS  = atp_pkg::GAIN_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  atp_pkg::t_load                          i_load,
    input  logic                                    i_first,
    input  logic                                    i_clr,
    input  logic                                    i_cfg_clr,
    input  logic signed [ANGLE_BITS-1:0]            i_setpoint,
    input  logic signed [ANGLE_BITS-1:0]            i_angle,
    input  logic signed [atp_pkg::FF_BITS-1:0]      i_ff,
    input  logic        [3*GAIN_BITS-1:0]           i_gains,
    output logic signed [atp_pkg::TORQUE_BITS-1:0]  o_torque
);

    localparam int IB  = atp_pkg::INTEG_BITS;
    localparam int FB  = atp_pkg::FF_BITS;
    localparam int PPW = GAIN_BITS + ANGLE_BITS + 1;
    localparam int PIW = GAIN_BITS + IB + 1;
    localparam int PDW = GAIN_BITS + ANGLE_BITS + 2;
    localparam int SW  = ((PDW > PIW) ? PDW : PIW) + 2;
    localparam int PW  = SW - atp_pkg::GAIN_FRAC;
    localparam int TW  = PW + 1;

    localparam logic signed [IB:0]   ISAT_HI = (IB+1)'({1'b0, {(IB-1){1'b1}}});
    localparam logic signed [IB:0]   ISAT_LO = -ISAT_HI - (IB+1)'(1);
    localparam logic signed [TW-1:0] TSAT_HI = TW'({1'b0, {(atp_pkg::TORQUE_BITS-1){1'b1}}});
    localparam logic signed [TW-1:0] TSAT_LO = -TSAT_HI - TW'(1);

    // loop state
    logic signed [IB-1:0]         r_integ;
    logic signed [ANGLE_BITS-1:0] r_last;

    // stage 1
    logic signed [ANGLE_BITS-1:0] r_err1;
    logic signed [IB-1:0]         r_integ1;
    logic signed [ANGLE_BITS:0]   r_diff1;
    logic signed [FB-1:0]         r_ff1;
    // stage 2
    logic signed [PPW-1:0]        r_prod_p;
    logic signed [PIW-1:0]        r_prod_i;
    logic signed [PDW-1:0]        r_prod_d;
    logic signed [FB-1:0]         r_ff2;
    // stage 3
    logic signed [PW-1:0]         r_pid3;
    logic signed [FB-1:0]         r_ff3;

    logic signed [ANGLE_BITS-1:0] w_err;
    logic signed [IB:0]           w_ibase;
    logic signed [IB:0]           w_isum;
    logic signed [IB-1:0]         w_integ;
    logic signed [ANGLE_BITS:0]   w_diff;
    logic        [GAIN_BITS-1:0]  w_kp;
    logic        [GAIN_BITS-1:0]  w_ki;
    logic        [GAIN_BITS-1:0]  w_kd;
    logic signed [PPW-1:0]        n_prod_p;
    logic signed [PIW-1:0]        n_prod_i;
    logic signed [PDW-1:0]        n_prod_d;
    logic signed [SW-1:0]         w_sum;
    logic signed [PW-1:0]         n_pid3;
    logic signed [TW-1:0]         w_tot;

    assign w_err   = ANGLE_BITS'(i_setpoint - i_angle);
    assign w_ibase = i_clr ? '0 : (IB+1)'(r_integ);
    assign w_isum  = w_ibase + (IB+1)'(w_err);
    assign w_diff  = i_first ? '0 : ((ANGLE_BITS+1)'(w_err) - (ANGLE_BITS+1)'(r_last));

    always_comb begin
        if (w_isum > ISAT_HI) begin
            w_integ = ISAT_HI[IB-1:0];
        end else if (w_isum < ISAT_LO) begin
            w_integ = ISAT_LO[IB-1:0];
        end else begin
            w_integ = w_isum[IB-1:0];
        end
    end

    assign w_kp = i_gains[GAIN_BITS-1:0];
    assign w_ki = i_gains[2*GAIN_BITS-1:GAIN_BITS];
    assign w_kd = i_gains[3*GAIN_BITS-1:2*GAIN_BITS];

    assign n_prod_p = $signed({1'b0, w_kp}) * r_err1;
    assign n_prod_i = $signed({1'b0, w_ki}) * r_integ1;
    assign n_prod_d = $signed({1'b0, w_kd}) * r_diff1;

    assign w_sum  = SW'(r_prod_p) + SW'(r_prod_i) + SW'(r_prod_d);
    // arithmetic shift is the floor of the Q8 product sum
    assign n_pid3 = PW'(w_sum >>> atp_pkg::GAIN_FRAC);

    assign w_tot = TW'(r_pid3) + TW'(r_ff3);

    always_comb begin
        if (w_tot > TSAT_HI) begin
            o_torque = TSAT_HI[atp_pkg::TORQUE_BITS-1:0];
        end else if (w_tot < TSAT_LO) begin
            o_torque = TSAT_LO[atp_pkg::TORQUE_BITS-1:0];
        end else begin
            o_torque = w_tot[atp_pkg::TORQUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else if (i_cfg_clr) begin
            r_integ <= '0;
        end else if (i_load.s1) begin
            r_integ <= w_integ;
            r_last  <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.s1) begin
            r_err1   <= w_err;
            r_integ1 <= w_integ;
            r_diff1  <= w_diff;
            r_ff1    <= i_ff;
        end
        if (i_load.s2) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
            r_ff2    <= r_ff1;
        end
        if (i_load.s3) begin
            r_pid3 <= n_pid3;
            r_ff3  <= r_ff2;
        end
    end

endmodule

[hw/rtl/atp_merge.sv]
module atp_merge #(
    parameter int ANGLE_BITS = atp_pkg::ANGLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  atp_pkg::t_load                          i_load,
    input  logic signed [atp_pkg::FF_BITS-1:0]      i_fx,
    input  logic signed [atp_pkg::FF_BITS-1:0]      i_fy,
    input  logic signed [atp_pkg::FF_BITS-1:0]      i_fz,
    input  logic                                    i_pub,
    input  logic signed [ANGLE_BITS-1:0]            i_held,
    input  logic signed [atp_pkg::TORQUE_BITS-1:0]  i_tx,
    input  logic signed [atp_pkg::TORQUE_BITS-1:0]  i_ty,
    input  logic signed [atp_pkg::TORQUE_BITS-1:0]  i_tz,
    output logic signed [atp_pkg::FF_BITS-1:0]      o_fx,
    output logic signed [atp_pkg::FF_BITS-1:0]      o_fy,
    output logic signed [atp_pkg::FF_BITS-1:0]      o_fz,
    output logic signed [atp_pkg::TORQUE_BITS-1:0]  o_tx,
    output logic signed [atp_pkg::TORQUE_BITS-1:0]  o_ty,
    output logic signed [atp_pkg::TORQUE_BITS-1:0]  o_tz,
    output logic                                    o_pub,
    output logic signed [ANGLE_BITS-1:0]            o_held
);

    localparam int SBW = 3*atp_pkg::FF_BITS + 1 + ANGLE_BITS;

    // side band travels alongside the lane stages
    logic [SBW-1:0] r_sb1;
    logic [SBW-1:0] r_sb2;
    logic [SBW-1:0] r_sb3;
    logic [SBW-1:0] r_sb4;

    always_ff @(posedge i_clk) begin
        if (i_load.s1) begin
            r_sb1 <= {i_fx, i_fy, i_fz, i_pub, i_held};
        end
        if (i_load.s2) begin
            r_sb2 <= r_sb1;
        end
        if (i_load.s3) begin
            r_sb3 <= r_sb2;
        end
        if (i_load.s4) begin
            r_sb4 <= r_sb3;
            o_tx  <= i_tx;
            o_ty  <= i_ty;
            o_tz  <= i_tz;
        end
    end

    assign {o_fx, o_fy, o_fz, o_pub, o_held} = r_sb4;

endmodule

[hw/rtl/attitude_pid_with_yaw_hold.sv]
// Three-axis attitude PID with yaw hold. One item per control tick: roll and
// pitch are driven to zero, yaw to a setpoint captured on the first tick and
// re-captured (integral cleared) while |yaw_command| exceeds yaw_threshold;
// the first tick after release raises setpoint_published. Rate: one item per
// clock sustained while the output is not stalled; each result passes the
// stages error/integral update, multiply, sum and shift, and saturate into
// the output register. The integral and hold state close their loop in the
// acceptance cycle, which is what lets items follow back to back. Gains are
// Q8.8 with the tick period folded in; a gains write clears that axis's
// integral. Write configuration only while no items are in flight.
module attitude_pid_with_yaw_hold #(
    parameter int ANGLE_BITS = atp_pkg::ANGLE_BITS_DEF,
    parameter int GAIN_BITS  = atp_pkg::GAIN_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // configuration
    input  logic                                      i_cfg_we,
    input  logic [atp_pkg::CFG_IDX_BITS-1:0]          i_cfg_idx,
    input  logic [atp_pkg::GAINS_REG_BITS-1:0]        i_cfg_data,
    // input items
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  logic signed [ANGLE_BITS-1:0]              i_roll_angle,
    input  logic signed [ANGLE_BITS-1:0]              i_pitch_angle,
    input  logic signed [ANGLE_BITS-1:0]              i_yaw_angle,
    input  logic                                      i_feedforward_present,
    input  logic signed [atp_pkg::FF_BITS-1:0]        i_force_ff_x,
    input  logic signed [atp_pkg::FF_BITS-1:0]        i_force_ff_y,
    input  logic signed [atp_pkg::FF_BITS-1:0]        i_force_ff_z,
    input  logic signed [atp_pkg::FF_BITS-1:0]        i_roll_torque_ff,
    input  logic signed [atp_pkg::FF_BITS-1:0]        i_pitch_torque_ff,
    input  logic signed [atp_pkg::FF_BITS-1:0]        i_yaw_command,
    // result items
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic signed [atp_pkg::FF_BITS-1:0]        o_force_x,
    output logic signed [atp_pkg::FF_BITS-1:0]        o_force_y,
    output logic signed [atp_pkg::FF_BITS-1:0]        o_force_z,
    output logic signed [atp_pkg::TORQUE_BITS-1:0]    o_roll_torque,
    output logic signed [atp_pkg::TORQUE_BITS-1:0]    o_pitch_torque,
    output logic signed [atp_pkg::TORQUE_BITS-1:0]    o_yaw_torque,
    output logic                                      o_setpoint_published,
    output logic signed [ANGLE_BITS-1:0]              o_held_yaw
);

    localparam int GPW = 3*GAIN_BITS + atp_pkg::GAINS_REG_BITS;

    // configuration registers
    logic [atp_pkg::GAINS_REG_BITS-1:0] r_roll_gains;
    logic [atp_pkg::GAINS_REG_BITS-1:0] r_pitch_gains;
    logic [atp_pkg::GAINS_REG_BITS-1:0] r_yaw_gains;
    logic [atp_pkg::THRESH_BITS-1:0]    r_thresh;

    // stage occupancy; stage 4 is the output register
    logic r_v1, r_v2, r_v3, r_v4;
    logic n_v1, n_v2, n_v3, n_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    atp_pkg::t_load w_load;

    atp_pkg::t_cfg_idx w_cfg_idx;
    logic w_clr_roll, w_clr_pitch, w_clr_yaw;

    // feedforward after the present flag
    logic signed [atp_pkg::FF_BITS-1:0] w_fx, w_fy, w_fz, w_tfx, w_tfy, w_ycmd;

    atp_pkg::t_hold               w_hold;
    logic signed [ANGLE_BITS-1:0] w_setpoint;

    logic [GPW-1:0] w_roll_pad, w_pitch_pad, w_yaw_pad;
    logic signed [atp_pkg::TORQUE_BITS-1:0] w_tx, w_ty, w_tz;

    // ---------------- configuration ----------------
    assign w_cfg_idx   = atp_pkg::t_cfg_idx'(i_cfg_idx);
    assign w_clr_roll  = i_cfg_we && (w_cfg_idx == atp_pkg::CFG_ROLL_GAINS);
    assign w_clr_pitch = i_cfg_we && (w_cfg_idx == atp_pkg::CFG_PITCH_GAINS);
    assign w_clr_yaw   = i_cfg_we && (w_cfg_idx == atp_pkg::CFG_YAW_GAINS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_gains  <= '0;
            r_pitch_gains <= '0;
            r_yaw_gains   <= '0;
            r_thresh      <= atp_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            case (w_cfg_idx)
                atp_pkg::CFG_ROLL_GAINS:  r_roll_gains  <= i_cfg_data;
                atp_pkg::CFG_PITCH_GAINS: r_pitch_gains <= i_cfg_data;
                atp_pkg::CFG_YAW_GAINS:   r_yaw_gains   <= i_cfg_data;
                atp_pkg::CFG_YAW_THRESH:  r_thresh      <= i_cfg_data[atp_pkg::THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // gain fields beyond the 48 register bits read as zero
    assign w_roll_pad  = {{(3*GAIN_BITS){1'b0}}, r_roll_gains};
    assign w_pitch_pad = {{(3*GAIN_BITS){1'b0}}, r_pitch_gains};
    assign w_yaw_pad   = {{(3*GAIN_BITS){1'b0}}, r_yaw_gains};

    // ---------------- pipeline flow ----------------
    // a stage takes a new item when empty or when its item moves on, so
    // bubbles close up behind a stalled output
    assign w_rdy4 = !r_v4 || i_out_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_load.s1 = i_in_valid && w_rdy1;
    assign w_load.s2 = r_v1 && w_rdy2;
    assign w_load.s3 = r_v2 && w_rdy3;
    assign w_load.s4 = r_v3 && w_rdy4;

    assign n_v1 = w_load.s1 || (r_v1 && !w_rdy2);
    assign n_v2 = w_load.s2 || (r_v2 && !w_rdy3);
    assign n_v3 = w_load.s3 || (r_v3 && !w_rdy4);
    assign n_v4 = w_load.s4 || (r_v4 && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_v4 <= n_v4;
        end
    end

    assign o_in_ready  = w_rdy1;
    assign o_out_valid = r_v4;

    // ---------------- front end ----------------
    assign w_fx   = i_feedforward_present ? i_force_ff_x      : '0;
    assign w_fy   = i_feedforward_present ? i_force_ff_y      : '0;
    assign w_fz   = i_feedforward_present ? i_force_ff_z      : '0;
    assign w_tfx  = i_feedforward_present ? i_roll_torque_ff  : '0;
    assign w_tfy  = i_feedforward_present ? i_pitch_torque_ff : '0;
    assign w_ycmd = i_feedforward_present ? i_yaw_command     : '0;

    atp_hold #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_hold (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_load.s1),
        .i_yaw      (i_yaw_angle),
        .i_cmd      (w_ycmd),
        .i_thresh   (r_thresh),
        .o_setpoint (w_setpoint),
        .o_hold     (w_hold)
    );

    // ---------------- axis lanes ----------------
    atp_lane #(
        .ANGLE_BITS (ANGLE_BITS),
        .GAIN_BITS  (GAIN_BITS)
    ) u_roll (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_first    (w_hold.first),
        .i_clr      (1'b0),
        .i_cfg_clr  (w_clr_roll),
        .i_setpoint ('0),
        .i_angle    (i_roll_angle),
        .i_ff       (w_tfx),
        .i_gains    (w_roll_pad[3*GAIN_BITS-1:0]),
        .o_torque   (w_tx)
    );

    atp_lane #(
        .ANGLE_BITS (ANGLE_BITS),
        .GAIN_BITS  (GAIN_BITS)
    ) u_pitch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_first    (w_hold.first),
        .i_clr      (1'b0),
        .i_cfg_clr  (w_clr_pitch),
        .i_setpoint ('0),
        .i_angle    (i_pitch_angle),
        .i_ff       (w_tfy),
        .i_gains    (w_pitch_pad[3*GAIN_BITS-1:0]),
        .o_torque   (w_ty)
    );

    atp_lane #(
        .ANGLE_BITS (ANGLE_BITS),
        .GAIN_BITS  (GAIN_BITS)
    ) u_yaw (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_first    (w_hold.first),
        .i_clr      (w_hold.clr_integ),
        .i_cfg_clr  (w_clr_yaw),
        .i_setpoint (w_setpoint),
        .i_angle    (i_yaw_angle),
        .i_ff       (w_ycmd),
        .i_gains    (w_yaw_pad[3*GAIN_BITS-1:0]),
        .o_torque   (w_tz)
    );

    // ---------------- merge and output register ----------------
    atp_merge #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_merge (
        .i_clk  (i_clk),
        .i_load (w_load),
        .i_fx   (w_fx),
        .i_fy   (w_fy),
        .i_fz   (w_fz),
        .i_pub  (w_hold.published),
        .i_held (w_setpoint),
        .i_tx   (w_tx),
        .i_ty   (w_ty),
        .i_tz   (w_tz),
        .o_fx   (o_force_x),
        .o_fy   (o_force_y),
        .o_fz   (o_force_z),
        .o_tx   (o_roll_torque),
        .o_ty   (o_pitch_torque),
        .o_tz   (o_yaw_torque),
        .o_pub  (o_setpoint_published),
        .o_held (o_held_yaw)
    );

`ifndef SYNTH
    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !i_out_ready) |-> !w_load.s4)
        else $error("output register overwritten while stalled");

    // a result only appears from an occupied stage 3
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v4) |-> $past(r_v3))
        else $error("result without an item in stage 3");

    // publication is a single tick and always comes with a recapture
    a_publish_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load.s1 && w_hold.published) |=> !w_hold.published)
        else $error("setpoint published on consecutive items");

    a_publish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load.s1 && w_hold.published) |-> w_hold.clr_integ)
        else $error("publication without yaw integral clear");
`endif

endmodule

[sim/attitude_pid_with_yaw_hold_test.sv]
module attitude_pid_with_yaw_hold_test;
    timeunit 1ns;
    timeprecision 1ps;

    // run is cut off here whatever happens
    localparam int    CYCLE_LIMIT = 40000;
    // torques reach their limits after some 260 ticks at full error
    localparam int    SAT_TICKS   = 300;
    localparam longint TQ_MAX     = 64'sd2147483647;
    localparam longint TQ_MIN     = -64'sd2147483648;
    localparam logic [atp_pkg::GAINS_REG_BITS-1:0] GAINS_MAX = '1;

    // one control tick as offered to the block
    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               ff_on;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic signed [15:0] troll;
        logic signed [15:0] tpitch;
        logic signed [15:0] ycmd;
    } t_tick;

    // thruster command produced for one tick
    typedef struct {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic               published;
        logic signed [15:0] held;
    } t_cmd;

    logic                                i_clk;
    logic                                i_rst_n     = 1'b0;
    logic                                i_cfg_we    = 1'b0;
    logic [atp_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx   = atp_pkg::CFG_ROLL_GAINS;
    logic [atp_pkg::GAINS_REG_BITS-1:0]  i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic signed [15:0]         i_roll_angle        = '0;
    logic signed [15:0]         i_pitch_angle       = '0;
    logic signed [15:0]         i_yaw_angle         = '0;
    logic                       i_feedforward_present = 1'b0;
    logic signed [15:0]         i_force_ff_x        = '0;
    logic signed [15:0]         i_force_ff_y        = '0;
    logic signed [15:0]         i_force_ff_z        = '0;
    logic signed [15:0]         i_roll_torque_ff    = '0;
    logic signed [15:0]         i_pitch_torque_ff   = '0;
    logic signed [15:0]         i_yaw_command       = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [15:0]         o_force_x;
    logic signed [15:0]         o_force_y;
    logic signed [15:0]         o_force_z;
    logic signed [31:0]         o_roll_torque;
    logic signed [31:0]         o_pitch_torque;
    logic signed [31:0]         o_yaw_torque;
    logic                       o_setpoint_published;
    logic signed [15:0]         o_held_yaw;

    attitude_pid_with_yaw_hold i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_roll_angle          (i_roll_angle),
        .i_pitch_angle         (i_pitch_angle),
        .i_yaw_angle           (i_yaw_angle),
        .i_feedforward_present (i_feedforward_present),
        .i_force_ff_x          (i_force_ff_x),
        .i_force_ff_y          (i_force_ff_y),
        .i_force_ff_z          (i_force_ff_z),
        .i_roll_torque_ff      (i_roll_torque_ff),
        .i_pitch_torque_ff     (i_pitch_torque_ff),
        .i_yaw_command         (i_yaw_command),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_force_x             (o_force_x),
        .o_force_y             (o_force_y),
        .o_force_z             (o_force_z),
        .o_roll_torque         (o_roll_torque),
        .o_pitch_torque        (o_pitch_torque),
        .o_yaw_torque          (o_yaw_torque),
        .o_setpoint_published  (o_setpoint_published),
        .o_held_yaw            (o_held_yaw)
    );

    // ---------------------------------------------------------------------
    // Controller model: axis 0 roll, 1 pitch, 2 yaw
    // ---------------------------------------------------------------------
    logic [atp_pkg::GAINS_REG_BITS-1:0] axis_gains [3];
    logic [atp_pkg::THRESH_BITS-1:0]    yaw_thresh;
    longint                    axis_integ [3];
    longint                    axis_prev_err [3];
    logic signed [15:0]        hold_yaw;
    bit                        hold_set;
    bit                        release_seen;
    bit                        fresh;          // no tick seen yet: no D term

    t_tick tick_queue [$];     // ticks waiting to be offered
    t_cmd  pending_cmds [$];   // commands predicted, not yet seen
    t_tick on_wire;            // tick currently driven on the input port

    bit steady = 1'b0;         // both sides stop idling while set
    int n_faults = 0;
    int n_cmds = 0;
    int n_cycles = 0;

    function automatic longint clip32(input longint x);
        if (x > TQ_MAX)
            return TQ_MAX;
        if (x < TQ_MIN)
            return TQ_MIN;
        return x;
    endfunction

    // one PID update; Q8.8 gains, floor on the final shift
    function automatic longint pid_axis(input int ax, input longint err);
        longint kp, ki, kd, d, sum;
        kp = axis_gains[ax][15:0];
        ki = axis_gains[ax][31:16];
        kd = axis_gains[ax][47:32];
        d = fresh ? 0 : err - axis_prev_err[ax];
        axis_integ[ax] = clip32(axis_integ[ax] + err);
        axis_prev_err[ax] = err;
        sum = kp * err + ki * axis_integ[ax] + kd * d;
        return sum >>> atp_pkg::GAIN_FRAC;
    endfunction

    function automatic t_cmd predict_commands(input t_tick t);
        t_cmd               c;
        logic signed [15:0] tr, tp, yc, err;
        longint             mag, thr;
        bit                 active;
        tr = t.ff_on ? t.troll  : 16'sd0;
        tp = t.ff_on ? t.tpitch : 16'sd0;
        yc = t.ff_on ? t.ycmd   : 16'sd0;
        c.fx = t.ff_on ? t.fx : 16'sd0;
        c.fy = t.ff_on ? t.fy : 16'sd0;
        c.fz = t.ff_on ? t.fz : 16'sd0;
        mag = yc;
        if (mag < 0)
            mag = -mag;
        thr = yaw_thresh;
        active = mag > thr;
        c.published = 1'b0;
        if (!hold_set) begin
            hold_yaw = t.yaw;
            hold_set = 1'b1;
        end
        // command large: setpoint follows yaw; first quiet tick publishes
        if (active) begin
            hold_yaw = t.yaw;
            axis_integ[2] = 0;
        end else if (release_seen) begin
            hold_yaw = t.yaw;
            axis_integ[2] = 0;
            c.published = 1'b1;
        end
        err = -t.roll;                 // 16-bit wrap, -pi stays -pi
        c.tx = clip32(tr + pid_axis(0, err));
        err = -t.pitch;
        c.ty = clip32(tp + pid_axis(1, err));
        err = hold_yaw - t.yaw;
        c.tz = clip32(yc + pid_axis(2, err));
        release_seen = active;
        fresh = 1'b0;
        c.held = hold_yaw;
        return c;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic write_reg(input atp_pkg::t_cfg_idx idx,
                             input logic [atp_pkg::GAINS_REG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            atp_pkg::CFG_ROLL_GAINS: begin
                axis_gains[0] = value;
                axis_integ[0] = 0;
            end
            atp_pkg::CFG_PITCH_GAINS: begin
                axis_gains[1] = value;
                axis_integ[1] = 0;
            end
            atp_pkg::CFG_YAW_GAINS: begin
                axis_gains[2] = value;
                axis_integ[2] = 0;
            end
            atp_pkg::CFG_YAW_THRESH: begin
                yaw_thresh = value[atp_pkg::THRESH_BITS-1:0];
            end
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(input logic [atp_pkg::GAINS_REG_BITS-1:0] r, p, y,
                           input logic [atp_pkg::GAINS_REG_BITS-1:0] thr);
        write_reg(atp_pkg::CFG_ROLL_GAINS, r);
        write_reg(atp_pkg::CFG_PITCH_GAINS, p);
        write_reg(atp_pkg::CFG_YAW_GAINS, y);
        write_reg(atp_pkg::CFG_YAW_THRESH, thr);
    endtask

    task automatic add_tick(input int roll, pitch, yaw, ff, fx, fy, fz, tr, tp, yc);
        t_tick t;
        t.roll = roll;   t.pitch = pitch; t.yaw = yaw;  t.ff_on = ff[0];
        t.fx = fx;       t.fy = fy;       t.fz = fz;
        t.troll = tr;    t.tpitch = tp;   t.ycmd = yc;
        tick_queue.push_back(t);
    endtask

    // angle: mostly near level, sometimes anywhere
    function automatic int pick_angle();
        if ($urandom_range(2) == 0)
            return $urandom;
        return int'($urandom_range(4000)) - 2000;
    endfunction

    function automatic t_tick make_tick();
        t_tick t;
        int    v;
        t.roll   = pick_angle();
        t.pitch  = pick_angle();
        t.yaw    = pick_angle();
        t.ff_on  = $urandom_range(99) < 80;
        t.fx     = $urandom;
        t.fy     = $urandom;
        t.fz     = $urandom;
        t.troll  = $urandom;
        t.tpitch = $urandom;
        // yaw command: inside the hold band, on its edge, or anywhere
        case ($urandom_range(9))
            0, 1, 2: v = $urandom_range(yaw_thresh);
            3, 4:    v = int'(yaw_thresh) + int'($urandom_range(1));
            default: v = $urandom;
        endcase
        if ($urandom_range(1))
            v = -v;
        t.ycmd = v;
        return t;
    endfunction

    task automatic add_random(input int n);
        repeat (n) tick_queue.push_back(make_tick());
    endtask

    // sender pauses until every queued tick is through and answered;
    // checked mid-cycle so that edge updates have all settled
    task automatic drain();
        while (tick_queue.size() != 0 || i_in_valid || pending_cmds.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got, inout bit bad);
        if (got !== want) begin
            bad = 1'b1;
            if (n_faults < 10)
                $display("item %0d %s: expected %h, got %h", n_cmds, name, want, got);
        end
    endtask

    // ---------------------------------------------------------------------
    // Clock and cycle limit
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Driver: offers queued ticks, holds each until taken
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                pending_cmds.push_back(predict_commands(on_wire));
            if (i_in_valid && !o_in_ready) begin
                // stalled, payload stays put
            end else if (tick_queue.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
                on_wire = tick_queue.pop_front();
                i_roll_angle          <= on_wire.roll;
                i_pitch_angle         <= on_wire.pitch;
                i_yaw_angle           <= on_wire.yaw;
                i_feedforward_present <= on_wire.ff_on;
                i_force_ff_x          <= on_wire.fx;
                i_force_ff_y          <= on_wire.fy;
                i_force_ff_z          <= on_wire.fz;
                i_roll_torque_ff      <= on_wire.troll;
                i_pitch_torque_ff     <= on_wire.tpitch;
                i_yaw_command         <= on_wire.ycmd;
                i_in_valid            <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each command, throttles the output side
    // ---------------------------------------------------------------------
    int hold_left = 0;

    always @(posedge i_clk) begin
        t_cmd want;
        bit   bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_cmds++;
            if (pending_cmds.size() == 0) begin
                if (n_faults < 10)
                    $display("item %0d: result with nothing expected", n_cmds);
                n_faults++;
            end else begin
                want = pending_cmds.pop_front();
                bad = 1'b0;
                check_field("force_x", want.fx, o_force_x, bad);
                check_field("force_y", want.fy, o_force_y, bad);
                check_field("force_z", want.fz, o_force_z, bad);
                check_field("roll_torque", want.tx, o_roll_torque, bad);
                check_field("pitch_torque", want.ty, o_pitch_torque, bad);
                check_field("yaw_torque", want.tz, o_yaw_torque, bad);
                check_field("setpoint_published", want.published,
                            o_setpoint_published, bad);
                check_field("held_yaw", want.held, o_held_yaw, bad);
                if (bad)
                    n_faults++;
            end
            // long back-pressure while the sender keeps going: pipeline fills
            if (n_cmds == 150)
                hold_left = 120;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || $urandom_range(99) >= 37;
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin
        axis_gains    = '{default: '0};
        axis_integ    = '{default: 0};
        axis_prev_err = '{default: 0};
        yaw_thresh    = atp_pkg::THRESH_RESET;
        hold_yaw      = '0;
        hold_set      = 1'b0;
        release_seen  = 1'b0;
        fresh         = 1'b1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: threshold left at its reset value
        write_reg(atp_pkg::CFG_ROLL_GAINS,  48'h0300_0020_0180);
        write_reg(atp_pkg::CFG_PITCH_GAINS, 48'h0140_0011_0255);
        write_reg(atp_pkg::CFG_YAW_GAINS,   48'h0210_0031_0099);
        // first tick, feedforward absent so even a big yaw command is ignored
        add_tick(500, -300, 1000, 0, 1234, -1234, 77, 999, -999, 5000);
        // roll error at pi; yaw command exactly at threshold keeps the hold
        add_tick(-32768, 32767, 1000, 1, -32768, 32767, -32768, 32767, -32768, 10);
        add_tick(32767, -32768, 1200, 1, 32767, -32768, 32767, -32768, 32767, -10);
        // hold released, recaptured while large, published on first quiet tick
        add_tick(0, 0, 5000, 1, 0, 0, 0, 0, 0, 11);
        add_tick(0, 0, 6000, 1, 0, 0, 0, 0, 0, -11);
        add_tick(0, 0, 6100, 1, 0, 0, 0, 0, 0, 0);
        add_tick(0, 0, 6200, 1, 0, 0, 0, 0, 0, 0);
        add_tick(0, 0, -100, 1, 0, 0, 0, 0, 0, -32768);
        // release via absent feedforward; setpoint becomes 0
        add_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 32767);
        // yaw error at pi
        add_tick(0, 0, -32768, 1, 0, 0, 0, 0, 0, 3);
        add_tick(-1, -1, -1, 1, -1, -1, -1, -1, -1, -1);
        add_tick(1, 1, 32767, 1, 1, 1, 1, 1, 1, 1);
        add_tick(100, -100, 32767, 1, 0, 0, 0, 0, 0, 32767);
        add_tick(100, -100, 0, 1, 0, 0, 0, 0, 0, 0);
        drain();

        // torque saturation at full rate, no idling:
        // roll and yaw errors pinned at -pi, pitch at just under +pi
        write_reg(atp_pkg::CFG_ROLL_GAINS,  GAINS_MAX);
        write_reg(atp_pkg::CFG_PITCH_GAINS, GAINS_MAX);
        write_reg(atp_pkg::CFG_YAW_GAINS,   GAINS_MAX);
        steady = 1'b1;
        add_tick(0, 0, 0, 1, 0, 0, 0, 0, 0, -32768);
        add_tick(0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        repeat (SAT_TICKS)
            add_tick(-32768, -32767, -32768, 1, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom_range(20) - 10);
        drain();
        steady = 1'b0;

        // random gains, narrow hold band
        set_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, 15'($urandom_range(300))});
        add_random(180);
        drain();

        // zero gains, widest band: only -32768 releases the hold
        set_all('0, '0, '0, GAINS_MAX);
        add_random(170);
        drain();

        // full gains, zero band: any nonzero command releases
        set_all(GAINS_MAX, GAINS_MAX, GAINS_MAX, {33'($urandom), 15'd0});
        add_random(180);
        drain();

        if (n_faults == 0 && pending_cmds.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
